@@ hw/rtl/lr_pkg.sv @@
// Shared types and codes for the line rasterizer.
`timescale 1ns / 1ps

package lr_pkg;

  // Screen size registers
  localparam int DIM_W = 12;
  typedef logic [DIM_W-1:0] dim_t;

  localparam int CFG_INDEX_W = 1;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_SCREEN_WIDTH  = 1'b0;
  localparam cfg_index_t CFG_SCREEN_HEIGHT = 1'b1;
  localparam dim_t SCREEN_WIDTH_RESET  = 12'd500;
  localparam dim_t SCREEN_HEIGHT_RESET = 12'd500;

  // Command codes
  typedef logic cmd_t;
  localparam cmd_t CMD_LOAD = 1'b0;
  localparam cmd_t CMD_STEP = 1'b1;

  // Octant cases, after the endpoint swap
  typedef logic [1:0] octant_t;
  localparam octant_t OCT_SHALLOW_UP   = 2'd0;
  localparam octant_t OCT_SHALLOW_DOWN = 2'd1;
  localparam octant_t OCT_STEEP_RIGHT  = 2'd2;
  localparam octant_t OCT_STEEP_LEFT   = 2'd3;

  localparam int COLOR_W = 24;
  typedef logic [COLOR_W-1:0] color_t;

  // Queue between setup and walker
  localparam int QUEUE_DEPTH = 2;

endpackage

@@ hw/rtl/line_rasterizer.sv @@
// Top level of the midpoint line rasterizer.
`timescale 1ns / 1ps

// Midpoint line rasterizer covering all eight octants.
// Input stream (s_*): s_tuser selects the command, load or step. A load
// transaction carries both endpoints and the color in s_tdata and yields no
// output; it replaces any line in progress. A step transaction yields one
// pixel of the active line, or nothing when no line is active.
// Output stream (m_*): one transaction per pixel with coordinates and color in
// m_tdata, the on-screen flag in m_tuser and the line's last pixel on m_tlast.
// Configuration: cfg_we writes cfg_data into the register picked by cfg_index
// (0 screen width, 1 screen height); write only while the block is idle.
// A step's pixel passes the front setup register, a queue slot and the output
// register, in that order, before it shows at m_*.
// Throughput: one transaction per cycle while the receiver does not stall,
// bounded by the add-and-compare of the error term in the walker.
// Reset (rst, synchronous): no line active, queue empty, screen 500 x 500.
// When the receiver stalls, the output register holds its pixel, steps back up
// in the two-entry queue and the front register, then s_tready drops; loads
// still drain from the queue as long as they are ahead of any waiting step.
module line_rasterizer #(
  parameter int COORD_BITS = 13
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // slave stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // command
  input  logic                                   s_tuser,
  // x_start, y_start, x_end, y_end, red_in, green_in, blue_in, zero pad
  input  logic [((4*COORD_BITS+24+7)/8)*8-1:0]   s_tdata,
  // master stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // pixel_x, pixel_y, red_out, green_out, blue_out, zero pad
  output logic [((2*COORD_BITS+24+7)/8)*8-1:0]   m_tdata,
  // on_screen
  output logic                                   m_tuser,
  // last_pixel
  output logic                                   m_tlast,
  // configuration write port
  input  logic                                   cfg_we,
  input  lr_pkg::cfg_index_t                     cfg_index,
  input  lr_pkg::dim_t                           cfg_data
);
  import lr_pkg::*;

  localparam int ENTRY_W = 6*COORD_BITS + 33;

  dim_t screen_width, screen_height;

  logic               fq_valid, fq_ready, qb_valid, qb_ready;
  logic [ENTRY_W-1:0] fq_data, qb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: begin
          screen_width <= screen_width;
        end
      endcase
    end
  end

  lr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  lr_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  lr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .q_valid       (qb_valid),
    .q_ready       (qb_ready),
    .q_data        (qb_data),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule

@@ hw/rtl/lr_front.sv @@
// Front end: accepts commands and computes line setup for loads.
`timescale 1ns / 1ps

module lr_front #(
  parameter int COORD_BITS = 13
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  lr_pkg::cmd_t                           s_tuser,
  input  logic [((4*COORD_BITS+24+7)/8)*8-1:0]   s_tdata,
  output logic                                   q_valid,
  input  logic                                   q_ready,
  output logic [6*COORD_BITS+32:0]               q_data
);
  import lr_pkg::*;

  localparam int C = COORD_BITS;
  localparam int D = COORD_BITS + 1;
  localparam int E = COORD_BITS + 4;

  typedef struct packed {
    cmd_t            cmd;
    logic [C-1:0]    cur_x;
    logic [C-1:0]    cur_y;
    logic [C-1:0]    major_end;
    logic [D-1:0]    delta_x;
    logic [D-1:0]    delta_y;
    logic [E-1:0]    error_term;
    octant_t         octant;
    color_t          color;
  } entry_t;

  logic signed [C-1:0] ax, ay, bx, by;
  logic signed [D-1:0] dx_raw, dy_raw, sdx, sdy;
  logic        [D-1:0] adx, ady;
  logic signed [E-1:0] ex, ey, err_init;
  logic                shallow, swap;
  entry_t              entry, held;
  logic                held_valid;

  assign ax = $signed(s_tdata[C-1:0]);
  assign ay = $signed(s_tdata[2*C-1:C]);
  assign bx = $signed(s_tdata[3*C-1:2*C]);
  assign by = $signed(s_tdata[4*C-1:3*C]);

  always_comb begin
    dx_raw  = D'(bx) - D'(ax);
    dy_raw  = D'(by) - D'(ay);
    adx     = dx_raw[D-1] ? D'(-dx_raw) : D'(dx_raw);
    ady     = dy_raw[D-1] ? D'(-dy_raw) : D'(dy_raw);
    shallow = (adx >= ady);
    swap    = shallow ? (ax > bx) : (ay > by);
    sdx     = swap ? -dx_raw : dx_raw;
    sdy     = swap ? -dy_raw : dy_raw;
    ex      = E'(sdx);
    ey      = E'(sdy);

    entry.cmd     = s_tuser;
    entry.cur_x   = swap ? bx : ax;
    entry.cur_y   = swap ? by : ay;
    if (shallow) begin
      entry.major_end = swap ? ax : bx;
      if (!sdy[D-1]) begin
        entry.octant = OCT_SHALLOW_UP;
        err_init     = (ey <<< 1) - ex;
      end else begin
        entry.octant = OCT_SHALLOW_DOWN;
        err_init     = (ey <<< 1) + ex;
      end
    end else begin
      entry.major_end = swap ? ay : by;
      if (!sdx[D-1]) begin
        entry.octant = OCT_STEEP_RIGHT;
        err_init     = ey - (ex <<< 1);
      end else begin
        entry.octant = OCT_STEEP_LEFT;
        err_init     = ey + (ex <<< 1);
      end
    end
    entry.delta_x    = sdx;
    entry.delta_y    = sdy;
    entry.error_term = err_init;
    // tdata color order is red, green, blue from the low end
    entry.color = {s_tdata[4*C +: 8], s_tdata[4*C+8 +: 8], s_tdata[4*C+16 +: 8]};
  end

  assign s_tready = !held_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      held <= entry;
    end
  end

  assign q_valid = held_valid;
  assign q_data  = held;

endmodule

@@ hw/rtl/lr_queue.sv @@
// Short FIFO between the setup front end and the pixel walker.
`timescale 1ns / 1ps

module lr_queue #(
  parameter int WIDTH = 111
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import lr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_data;
    end
  end

endmodule

@@ hw/rtl/lr_back.sv @@
// Back end: walks the active line one pixel per step and drives the output register.
`timescale 1ns / 1ps

module lr_back #(
  parameter int COORD_BITS = 13
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lr_pkg::dim_t                           screen_width,
  input  lr_pkg::dim_t                           screen_height,
  input  logic                                   q_valid,
  output logic                                   q_ready,
  input  logic [6*COORD_BITS+32:0]               q_data,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((2*COORD_BITS+24+7)/8)*8-1:0]   m_tdata,
  output logic                                   m_tuser,
  output logic                                   m_tlast
);
  import lr_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int D     = COORD_BITS + 1;
  localparam int E     = COORD_BITS + 4;
  localparam int OUT_W = ((2*COORD_BITS+24+7)/8)*8;
  localparam int CMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

  typedef struct packed {
    cmd_t            cmd;
    logic [C-1:0]    cur_x;
    logic [C-1:0]    cur_y;
    logic [C-1:0]    major_end;
    logic [D-1:0]    delta_x;
    logic [D-1:0]    delta_y;
    logic [E-1:0]    error_term;
    octant_t         octant;
    color_t          color;
  } entry_t;

  entry_t head;

  // walker state
  logic signed [C-1:0] cursor_x, cursor_y, major_end;
  logic signed [D-1:0] delta_x, delta_y;
  logic signed [E-1:0] error_term;
  octant_t             octant_case;
  logic                line_active;
  color_t              line_color;

  logic signed [C-1:0] cursor_x_next, cursor_y_next, major;
  logic signed [E-1:0] error_term_next, dx2, dy2;
  logic                out_free, pop, emit, last, vis, err_neg, err_zero;

  assign head     = q_data;
  assign out_free = !m_tvalid || m_tready;
  assign q_ready  = (head.cmd == CMD_LOAD) || out_free;
  assign pop      = q_valid && q_ready;
  assign emit     = pop && (head.cmd == CMD_STEP) && line_active;

  assign major = octant_case[1] ? cursor_y : cursor_x;
  assign last  = (major >= major_end);
  assign vis   = !cursor_x[C-1] && (CMP_W'(cursor_x[C-2:0]) < CMP_W'(screen_width)) &&
                 !cursor_y[C-1] && (CMP_W'(cursor_y[C-2:0]) < CMP_W'(screen_height));

  assign dx2      = E'(delta_x) <<< 1;
  assign dy2      = E'(delta_y) <<< 1;
  assign err_neg  = error_term[E-1];
  assign err_zero = (error_term == '0);

  // midpoint update; the minor axis moves when the error crosses its tie rule
  always_comb begin
    cursor_x_next   = cursor_x;
    cursor_y_next   = cursor_y;
    error_term_next = error_term;
    unique case (octant_case)
      OCT_SHALLOW_UP: begin
        cursor_x_next = cursor_x + 1'b1;
        if (!err_neg) begin
          cursor_y_next   = cursor_y + 1'b1;
          error_term_next = error_term + dy2 - dx2;
        end else begin
          error_term_next = error_term + dy2;
        end
      end
      OCT_SHALLOW_DOWN: begin
        cursor_x_next = cursor_x + 1'b1;
        if (err_neg || err_zero) begin
          cursor_y_next   = cursor_y - 1'b1;
          error_term_next = error_term + dy2 + dx2;
        end else begin
          error_term_next = error_term + dy2;
        end
      end
      OCT_STEEP_RIGHT: begin
        cursor_y_next = cursor_y + 1'b1;
        if (err_neg || err_zero) begin
          cursor_x_next   = cursor_x + 1'b1;
          error_term_next = error_term + dy2 - dx2;
        end else begin
          error_term_next = error_term - dx2;
        end
      end
      OCT_STEEP_LEFT: begin
        cursor_y_next = cursor_y + 1'b1;
        if (!err_neg) begin
          cursor_x_next   = cursor_x - 1'b1;
          error_term_next = error_term - dy2 - dx2;
        end else begin
          error_term_next = error_term - dx2;
        end
      end
      default: begin
        error_term_next = error_term;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      octant_case <= OCT_SHALLOW_UP;
    end else if (pop && head.cmd == CMD_LOAD) begin
      line_active <= 1'b1;
      octant_case <= head.octant;
    end else if (emit && last) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.cmd == CMD_LOAD) begin
      cursor_x   <= head.cur_x;
      cursor_y   <= head.cur_y;
      major_end  <= head.major_end;
      delta_x    <= head.delta_x;
      delta_y    <= head.delta_y;
      error_term <= head.error_term;
      line_color <= head.color;
    end else if (emit && !last) begin
      cursor_x   <= cursor_x_next;
      cursor_y   <= cursor_y_next;
      error_term <= error_term_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= OUT_W'({line_color[7:0], line_color[15:8], line_color[23:16],
                         cursor_y, cursor_x});
      m_tuser <= vis;
      m_tlast <= last;
    end
  end

endmodule

@@ test/tb_line_rasterizer.sv @@
// Self-checking testbench for the midpoint line rasterizer.
`timescale 1ns / 1ps

module tb_line_rasterizer;
  import lr_pkg::*;

  localparam int CB = 13;
  localparam int S_W = ((4*CB+24+7)/8)*8;
  localparam int M_W = ((2*CB+24+7)/8)*8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES = 5;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    cmd_t       cmd;
    coord_t     xs;
    coord_t     ys;
    coord_t     xe;
    coord_t     ye;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } line_cmd_t;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       on;
    logic       last;
  } pixel_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    line_cmd_t item;
    logic      typed;
    logic      yields;
    pixel_t    want;
  } table_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic             s_tuser = CMD_STEP;
  logic [S_W-1:0]   s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [M_W-1:0]   m_tdata;
  logic             m_tuser;
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  cfg_index_t       cfg_index = CFG_SCREEN_WIDTH;
  dim_t             cfg_data = '0;

  line_rasterizer #(.COORD_BITS(CB)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // walker state mirrored by the predictor
  int       walk_x, walk_y, walk_stop, run_dx, run_dy, walk_err;
  octant_t  walk_oct;
  bit       walk_on;
  color_t   walk_color;
  dim_t     scr_w = SCREEN_WIDTH_RESET;
  dim_t     scr_h = SCREEN_HEIGHT_RESET;

  pixel_t     pixel_fifo[$];
  table_row_t line_table[$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int items_counted = 0;
  int loads_sent = 0;
  int pixels_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 30)
      $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic cmp_field(input string name, input logic signed [31:0] got,
                           input logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Midpoint walker: a load sets up the line, a step emits the current pixel
  // and moves the cursor along the major axis.
  task automatic trace_item(input line_cmd_t it, output bit made, output pixel_t pix);
    int ax, ay, bx, by, dx, dy, major;
    made = 1'b0;
    pix = '0;
    if (it.cmd == CMD_LOAD) begin
      ax = it.xs;
      ay = it.ys;
      bx = it.xe;
      by = it.ye;
      dx = bx - ax;
      dy = by - ay;
      walk_color = {it.r, it.g, it.b};
      if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) begin
        if (ax <= bx) begin
          walk_x = ax; walk_y = ay; walk_stop = bx;
        end else begin
          walk_x = bx; walk_y = by; walk_stop = ax;
          dx = -dx; dy = -dy;
        end
        if (dy >= 0) begin
          walk_oct = OCT_SHALLOW_UP;
          walk_err = 2 * dy - dx;
        end else begin
          walk_oct = OCT_SHALLOW_DOWN;
          walk_err = 2 * dy + dx;
        end
      end else begin
        if (ay <= by) begin
          walk_x = ax; walk_y = ay; walk_stop = by;
        end else begin
          walk_x = bx; walk_y = by; walk_stop = ay;
          dx = -dx; dy = -dy;
        end
        if (dx >= 0) begin
          walk_oct = OCT_STEEP_RIGHT;
          walk_err = dy - 2 * dx;
        end else begin
          walk_oct = OCT_STEEP_LEFT;
          walk_err = dy + 2 * dx;
        end
      end
      run_dx = dx;
      run_dy = dy;
      walk_on = 1'b1;
    end else if (walk_on) begin
      made = 1'b1;
      major = (walk_oct == OCT_SHALLOW_UP || walk_oct == OCT_SHALLOW_DOWN) ? walk_x : walk_y;
      pix.x = coord_t'(walk_x);
      pix.y = coord_t'(walk_y);
      {pix.r, pix.g, pix.b} = walk_color;
      pix.on = walk_x >= 0 && walk_x < int'(scr_w) && walk_y >= 0 && walk_y < int'(scr_h);
      pix.last = major >= walk_stop;
      if (pix.last) begin
        walk_on = 1'b0;
      end else begin
        case (walk_oct)
          OCT_SHALLOW_UP: begin
            if (walk_err >= 0) begin walk_y++; walk_err -= 2 * run_dx; end
            walk_err += 2 * run_dy;
            walk_x++;
          end
          OCT_SHALLOW_DOWN: begin
            if (walk_err <= 0) begin walk_y--; walk_err += 2 * run_dx; end
            walk_err += 2 * run_dy;
            walk_x++;
          end
          OCT_STEEP_RIGHT: begin
            if (walk_err <= 0) begin walk_x++; walk_err += 2 * run_dy; end
            walk_err -= 2 * run_dx;
            walk_y++;
          end
          default: begin
            if (walk_err >= 0) begin walk_x--; walk_err -= 2 * run_dy; end
            walk_err -= 2 * run_dx;
            walk_y++;
          end
        endcase
      end
    end
  endtask

  // Drives one transaction on the input stream, with random gaps ahead of it,
  // and records the expected pixel once the block has taken it.
  task automatic send_item(input line_cmd_t it, input bit typed = 1'b0,
                           input bit yields = 1'b0, input pixel_t want = '0);
    bit     made;
    pixel_t pix;
    while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= S_W'({it.b, it.g, it.r, it.ye, it.xe, it.ys, it.xs});
    do @(posedge clk); while (!s_tready);
    if (it.cmd == CMD_LOAD) loads_sent++;
    if (it.cmd == CMD_LOAD || walk_on) items_counted++;
    trace_item(it, made, pix);
    if (typed) begin
      if (yields) pixel_fifo.push_back(want);
    end else if (made) begin
      pixel_fifo.push_back(pix);
    end
  endtask

  function automatic line_cmd_t rand_item(input cmd_t c);
    line_cmd_t it;
    it.cmd = c;
    it.xs = coord_t'($urandom);
    it.ys = coord_t'($urandom);
    it.xe = coord_t'($urandom);
    it.ye = coord_t'($urandom);
    {it.r, it.g, it.b} = 24'($urandom);
    return it;
  endfunction

  // mostly near the screen, some anywhere, some hugging the coordinate limits
  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($urandom_range(0, 8191)) - 4096;
      3:       return $urandom_range(0, 1) ? 4095 - int'($urandom_range(0, 6))
                                           : -4096 + int'($urandom_range(0, 6));
      default: return int'($urandom_range(0, 540)) - 20;
    endcase
  endfunction

  function automatic coord_t end_coord(input int start);
    int v;
    v = start + (($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 120)) - 60
                                               : int'($urandom_range(0, 24)) - 12);
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return coord_t'(v);
  endfunction

  // A whole line: load, then steps up to the end; sometimes cut short so the
  // next load replaces it, sometimes stepped past the end.
  task automatic draw_random_line();
    line_cmd_t it;
    int xs, ys, adx, ady, len, nsteps, roll;
    it = rand_item(CMD_LOAD);
    xs = pick_coord();
    ys = pick_coord();
    it.xs = coord_t'(xs);
    it.ys = coord_t'(ys);
    it.xe = end_coord(xs);
    it.ye = end_coord(ys);
    adx = int'(it.xe) - xs;
    ady = int'(it.ye) - ys;
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    len = (adx > ady ? adx : ady) + 1;
    roll = $urandom_range(0, 9);
    if (roll == 0) nsteps = $urandom_range(0, len - 1);
    else if (roll == 1) nsteps = len + $urandom_range(1, 3);
    else nsteps = len;
    send_item(it);
    repeat (nsteps) send_item(rand_item(CMD_STEP));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pixel_fifo.size() != 0) @(posedge clk);
    // loads leave nothing to wait on, so cover the pipeline depth as well
    repeat (8) @(posedge clk);
  endtask

  task automatic write_screen(input dim_t w, input dim_t h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
  endtask

  task automatic tab_load(input int xs, input int ys, input int xe, input int ye,
                          input color_t c);
    table_row_t row;
    row = '0;
    row.item.cmd = CMD_LOAD;
    row.item.xs = coord_t'(xs);
    row.item.ys = coord_t'(ys);
    row.item.xe = coord_t'(xe);
    row.item.ye = coord_t'(ye);
    {row.item.r, row.item.g, row.item.b} = c;
    line_table.push_back(row);
  endtask

  task automatic tab_step();
    table_row_t row;
    row = '0;
    row.item.cmd = CMD_STEP;
    line_table.push_back(row);
  endtask

  task automatic tab_step_none();
    table_row_t row;
    row = '0;
    row.item.cmd = CMD_STEP;
    row.typed = 1'b1;
    line_table.push_back(row);
  endtask

  task automatic tab_step_want(input int x, input int y, input color_t c,
                               input bit on, input bit last);
    table_row_t row;
    row = '0;
    row.item.cmd = CMD_STEP;
    row.typed = 1'b1;
    row.yields = 1'b1;
    row.want.x = coord_t'(x);
    row.want.y = coord_t'(y);
    {row.want.r, row.want.g, row.want.b} = c;
    row.want.on = on;
    row.want.last = last;
    line_table.push_back(row);
  endtask

  // receiver side: random backpressure per phase
  always @(posedge clk)
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.x = m_tdata[CB-1:0];
      got.y = m_tdata[2*CB-1:CB];
      got.r = m_tdata[2*CB+7:2*CB];
      got.g = m_tdata[2*CB+15:2*CB+8];
      got.b = m_tdata[2*CB+23:2*CB+16];
      got.on = m_tuser;
      got.last = m_tlast;
      if (pixel_fifo.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel at (%0d, %0d)", got.x, got.y));
      end else begin
        want = pixel_fifo.pop_front();
        pixels_checked++;
        cmp_field("pixel_x", got.x, want.x);
        cmp_field("pixel_y", got.y, want.y);
        cmp_field("red_out", got.r, want.r);
        cmp_field("green_out", got.g, want.g);
        cmp_field("blue_out", got.b, want.b);
        cmp_field("on_screen", got.on, want.on);
        cmp_field("last_pixel", got.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycle_count, pixel_fifo.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // per phase: screen size, sender gap and receiver stall percentages
  dim_t phase_w[NUM_PHASES]   = '{12'd640, 12'd1, 12'd2048, 12'd4095, 12'd0};
  dim_t phase_h[NUM_PHASES]   = '{12'd480, 12'd2048, 12'd1, 12'd0, 12'd4095};
  int   phase_gap[NUM_PHASES]   = '{0, 51, 0, 25, 0};
  int   phase_stall[NUM_PHASES] = '{0, 0, 51, 25, 0};

  initial begin
    int        start_items, roll;
    line_cmd_t it;

    // directed rows run against the reset screen of 500 x 500
    tab_step_none();                                   // step before any load
    tab_load(10, 20, 10, 20, 24'hFF00A5);              // equal endpoints
    tab_step_want(10, 20, 24'hFF00A5, 1'b1, 1'b1);
    tab_step_none();                                   // line already finished
    tab_load(-4096, -4096, -4096, -4096, 24'h000000);
    tab_step_want(-4096, -4096, 24'h000000, 1'b0, 1'b1);
    tab_load(4095, 4095, 4095, 4095, 24'hFFFFFF);
    tab_step_want(4095, 4095, 24'hFFFFFF, 1'b0, 1'b1);
    tab_load(499, 0, 501, 0, 24'h123456);              // crosses the right edge
    tab_step_want(499, 0, 24'h123456, 1'b1, 1'b0);
    tab_step_want(500, 0, 24'h123456, 1'b0, 1'b0);
    tab_step_want(501, 0, 24'h123456, 1'b0, 1'b1);
    tab_load(8, 0, 0, 3, 24'h3C5A7E);                  // shallow falling after swap
    tab_step();
    tab_step();
    tab_load(0, 0, 2, 6, 24'h8899AA);                  // steep rightward
    tab_step();
    tab_step();
    tab_load(3, 0, 0, 9, 24'hC0FFEE);                  // steep leftward
    tab_step();
    tab_step();
    tab_load(-4096, 4095, 4095, -4096, 24'h5A5A5A);    // full-range diagonal
    tab_step();
    tab_step();
    tab_load(100, 100, 103, 100, 24'h0F0F0F);          // replaces the active line
    tab_step();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (line_table[i])
      send_item(line_table[i].item, line_table[i].typed, line_table[i].yields,
                line_table[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_screen(phase_w[p], phase_h[p]);
      send_gap_pct = phase_gap[p];
      recv_stall_pct = phase_stall[p];
      start_items = items_counted;
      while (items_counted - start_items < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          draw_random_line();
        end else if (roll < 93) begin
          repeat ($urandom_range(1, 3)) send_item(rand_item(CMD_STEP));
        end else begin
          // unrestricted endpoints, usually long, left unfinished
          it = rand_item(CMD_LOAD);
          send_item(it);
          repeat ($urandom_range(0, 5)) send_item(rand_item(CMD_STEP));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("sent %0d line loads over %0d screen settings and all four idle mixes",
             loads_sent, NUM_PHASES + 1);
    $display("checked %0d pixels, %0d mismatches", pixels_checked, mismatch_count);
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_queue.sv
hw/rtl/lr_back.sv
hw/rtl/line_rasterizer.sv
test/tb_line_rasterizer.sv
